>>> hdl/lre_pkg.sv
// Shared types and constants for the LPC residual encoder.
package lre_pkg;

  localparam int OP_W     = 2;
  localparam int IDX_W    = 5;
  localparam int COEF_W   = 16;
  localparam int ORDER_W  = 6;
  localparam int SHIFT_W  = 5;
  localparam int VALUE_W  = 32;
  localparam int TOTAL_W  = 48;
  localparam int CFG_W    = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_COEF   = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
  localparam logic [OP_W-1:0] OP_BLOCK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT = 1'b1;

  localparam logic KIND_WARM  = 1'b0;
  localparam logic KIND_RESID = 1'b1;

  typedef struct packed {
    logic ready;       // input side open
    logic accept;      // input transfer this cycle
    logic acc_clear;   // zero the prediction accumulator
    logic tap_issue;   // feed one tap into the MAC pipe
    logic shift_load;  // register the shifted prediction
    logic res_load;    // register the saturated residual
    logic emit_warm;   // load output with a warmup sample
    logic emit_resid;  // load output with a residual
  } lre_cmd_t;

  typedef struct packed {
    logic is_sample;   // incoming item is a sample
    logic warm;        // block still in warmup
    logic ord_zero;    // no taps in use
    logic last_tap;    // current tap is the last one
    logic mac_busy;    // products still in flight
    logic out_free;    // output register can take a result
  } lre_status_t;

endpackage

>>> hdl/lre_if.sv
// Valid/ready channel interfaces for input items and results.
interface lre_in_if #(
  parameter int SAMPLE_BITS = 24
);
  import lre_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [OP_W-1:0]               operation;
  logic [IDX_W-1:0]              coef_index;
  logic signed [COEF_W-1:0]      coef_value;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, operation, coef_index, coef_value, sample, input ready);
  modport sink (input valid, operation, coef_index, coef_value, sample, output ready);
endinterface

interface lre_out_if;
  import lre_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [VALUE_W-1:0] value;
  logic [TOTAL_W-1:0]        abs_total;

  modport source (output valid, kind, value, abs_total, input ready);
  modport sink (input valid, kind, value, abs_total, output ready);
endinterface

>>> hdl/lpc_residual_encoder_unit.sv
// LPC residual encoder top level: controller, datapath and channel hookup.
//
// Input channel "items" carries one of: coefficient write (tap index and
// value), sample, or start of block. Coefficient writes and block starts
// produce no result. Each sample produces one result on
// channel "results": a warmup pass-through for the first 'order' samples of
// a block, then a residual (sample minus shifted prediction, saturated to
// 32 bits) plus the saturating block total of absolute residuals.
// Registers order and shift are to be written on the cfg port only while idle; the block leaves this rule to the user.
// A warmup result is loaded into the output register from the evaluate step
// after its input transfer; a residual passes through the single shared
// multiply-accumulate that walks the taps one per cycle through a
// read/multiply/add pipe, then drain, shift, residual and load steps.
// One sample is in flight at a time; the next item is taken the cycle after
// the previous result is loaded into the output register, so the input stays
// closed while a sample is in flight.
// A stalled receiver holds the result in the output register; the next
// sample is computed but waits to be loaded until that transfer completes.
// Reset (synchronous) clears order, shift, history, block count, total and
// the output valid; coefficients must be written before use.
module lpc_residual_encoder_unit import lre_pkg::*; #(
  parameter int MAX_ORDER   = 32,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  lre_in_if.sink               items,
  lre_out_if.source            results
);

  localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  lre_cmd_t      cmd;
  lre_status_t   status;
  logic [AW-1:0] tap;

  assign items.ready = cmd.ready;

  lre_ctrl #(
    .MAX_ORDER (MAX_ORDER)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .status   (status),
    .cmd      (cmd),
    .tap      (tap)
  );

  lre_datapath #(
    .MAX_ORDER   (MAX_ORDER),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .operation     (items.operation),
    .coef_index    (items.coef_index),
    .coef_value    (items.coef_value),
    .sample        (items.sample),
    .cmd           (cmd),
    .tap           (tap),
    .status        (status),
    .out_ready     (results.ready),
    .out_valid     (results.valid),
    .out_kind      (results.kind),
    .out_value     (results.value),
    .out_abs_total (results.abs_total)
  );

endmodule

>>> hdl/lre_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lre_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/lre_ctrl.sv
// Sequencer for the LPC residual encoder: dispatch, tap loop, residual steps.
module lre_ctrl import lre_pkg::*; #(
  parameter int MAX_ORDER = 32,
  localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  lre_status_t   status,
  output lre_cmd_t      cmd,
  output logic [AW-1:0] tap
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_RESID = 3'd5;
  localparam logic [2:0] S_ACCUM = 3'd6;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [AW-1:0] tap_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tap   <= '0;
    end else begin
      state <= state_next;
      tap   <= tap_next;
    end
  end

  always_comb begin
    state_next = state;
    tap_next   = tap;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.ready  = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && status.is_sample) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status.warm) begin
          if (status.out_free) begin
            cmd.emit_warm = 1'b1;
            state_next    = S_IDLE;
          end
        end else begin
          cmd.acc_clear = 1'b1;
          tap_next      = '0;
          state_next    = status.ord_zero ? S_DRAIN : S_MAC;
        end
      end
      S_MAC: begin
        cmd.tap_issue = 1'b1;
        if (status.last_tap) begin
          state_next = S_DRAIN;
        end else begin
          tap_next = tap + AW'(1);
        end
      end
      S_DRAIN: begin
        if (!status.mac_busy) begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift_load = 1'b1;
        state_next     = S_RESID;
      end
      S_RESID: begin
        cmd.res_load = 1'b1;
        state_next   = S_ACCUM;
      end
      S_ACCUM: begin
        if (status.out_free) begin
          cmd.emit_resid = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/lre_datapath.sv
// Datapath: config registers, coefficient RAM, history, MAC pipe, residual and output.
module lre_datapath import lre_pkg::*; #(
  parameter int MAX_ORDER   = 32,
  parameter int SAMPLE_BITS = 24,
  localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic [OP_W-1:0]               operation,
  input  logic [IDX_W-1:0]              coef_index,
  input  logic signed [COEF_W-1:0]      coef_value,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  lre_cmd_t                      cmd,
  input  logic [AW-1:0]                 tap,
  output lre_status_t                   status,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_kind,
  output logic [VALUE_W-1:0]            out_value,
  output logic [TOTAL_W-1:0]            out_abs_total
);

  localparam int PW    = COEF_W + SAMPLE_BITS;
  localparam int ACC_W = PW + AW + 1;
  localparam int RW    = ACC_W + 1;
  localparam logic [ORDER_W-1:0] MAX_ORD = ORDER_W'(MAX_ORDER);

  logic [ORDER_W-1:0]            order_reg;
  logic [SHIFT_W-1:0]            shift_reg;
  logic [ORDER_W-1:0]            ord_eff;
  logic [ORDER_W-1:0]            block_count;
  logic [TOTAL_W-1:0]            abs_accum;
  logic signed [SAMPLE_BITS-1:0] x_reg;
  logic signed [SAMPLE_BITS-1:0] hist [MAX_ORDER];
  logic signed [SAMPLE_BITS-1:0] hist_q;
  logic [COEF_W-1:0]             coef_rd;
  logic                          coef_we;
  logic                          v1;
  logic                          v2;
  logic signed [PW-1:0]          prod_q;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       pred_q;
  logic signed [RW-1:0]          res;
  logic [RW-32:0]                res_top;
  logic [VALUE_W-1:0]            res_sat;
  logic [VALUE_W-1:0]            res_q;
  logic [VALUE_W-1:0]            mag;
  logic [TOTAL_W:0]              sum_wide;
  logic [TOTAL_W-1:0]            abs_next;
  logic signed [VALUE_W-1:0]     x_ext;
  logic                          blk_clear;
  logic                          hist_push;

  assign ord_eff   = (order_reg > MAX_ORD) ? MAX_ORD : order_reg;
  assign coef_we   = cmd.accept && (operation == OP_COEF) &&
                     ({1'b0, coef_index} < MAX_ORD);
  assign blk_clear = cmd.accept && (operation == OP_BLOCK);
  assign hist_push = cmd.emit_warm || cmd.emit_resid;
  assign x_ext     = VALUE_W'(x_reg);

  assign status.is_sample = (operation == OP_SAMPLE);
  assign status.warm      = (block_count < ord_eff);
  assign status.ord_zero  = (ord_eff == '0);
  assign status.last_tap  = ((ORDER_W'(tap) + ORDER_W'(1)) == ord_eff);
  assign status.mac_busy  = v1 || v2;
  assign status.out_free  = !out_valid || out_ready;

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      order_reg <= '0;
      shift_reg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORDER: order_reg <= cfg_data;
        REG_SHIFT: shift_reg <= cfg_data[SHIFT_W-1:0];
        default:   ;
      endcase
    end
  end

  lre_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_ORDER)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_index[AW-1:0]),
    .wdata (coef_value),
    .raddr (tap),
    .rdata (coef_rd)
  );

  // sample history, newest first
  always_ff @(posedge clk) begin
    if (rst || blk_clear) begin
      for (int i = 0; i < MAX_ORDER; i++) begin
        hist[i] <= '0;
      end
    end else if (hist_push) begin
      hist[0] <= x_reg;
      for (int i = 1; i < MAX_ORDER; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  // block bookkeeping
  always_ff @(posedge clk) begin
    if (rst || blk_clear) begin
      block_count <= '0;
      abs_accum   <= '0;
    end else begin
      if (cmd.emit_warm) begin
        block_count <= block_count + ORDER_W'(1);
      end
      if (cmd.emit_resid) begin
        abs_accum <= abs_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && status.is_sample) begin
      x_reg <= sample;
    end
  end

  // MAC pipe: RAM/history read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.tap_issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    hist_q <= hist[tap];
    prod_q <= $signed(coef_rd) * hist_q;
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod_q);
    end
    if (cmd.shift_load) begin
      pred_q <= acc >>> shift_reg;
    end
    if (cmd.res_load) begin
      res_q <= res_sat;
    end
  end

  // residual with 32-bit saturation
  assign res     = RW'(x_reg) - RW'(pred_q);
  assign res_top = res[RW-1:31];
  always_comb begin
    if ((&res_top) || !(|res_top)) begin
      res_sat = res[VALUE_W-1:0];
    end else if (res[RW-1]) begin
      res_sat = 32'h8000_0000;
    end else begin
      res_sat = 32'h7FFF_FFFF;
    end
  end

  // magnitude and saturating block total
  assign mag      = res_q[VALUE_W-1] ? (~res_q + VALUE_W'(1)) : res_q;
  assign sum_wide = {1'b0, abs_accum} + (TOTAL_W + 1)'(mag);
  assign abs_next = sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_wide[TOTAL_W-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hist_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_warm) begin
      out_kind      <= KIND_WARM;
      out_value     <= x_ext;
      out_abs_total <= abs_accum;
    end else if (cmd.emit_resid) begin
      out_kind      <= KIND_RESID;
      out_value     <= res_q;
      out_abs_total <= abs_next;
    end
  end

endmodule
